### rtl/swts_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sorted window trimmed sum block.
// Used by swts_scan and sorted_window_trimmed_sum; depends on nothing else.
package swts_pkg;

  localparam int WINDOW_LEN_DEF = 25;
  localparam int SAMPLE_W       = 16;
  localparam int CFG_W          = 5;
  localparam int APB_ADDR_W     = 3;
  localparam int APB_DATA_W     = 32;

  localparam logic [CFG_W-1:0] SKIP_RESET = 5'd1;
  localparam logic [CFG_W-1:0] KEEP_RESET = 5'd20;

  typedef enum logic [0:0] {
    REG_SKIP_LARGEST = 1'b0,
    REG_KEEP_COUNT   = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Controls from the sequencer to the merge datapath.
  typedef struct packed {
    logic clear;
    logic run;
    logic step;
  } scan_ctl_t;

  // Progress flags from the merge datapath.
  typedef struct packed {
    logic inserted;
    logic removed;
  } scan_stat_t;

endpackage

### rtl/swts_ram.sv
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// A read and a write to the same address in one cycle return the old contents.
module swts_ram #(
  parameter int DEPTH  = 25,
  parameter int DATA_W = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/swts_scan.sv
`timescale 1ns / 1ps
// Merge datapath: streams the ranked memory once, drops one copy of the evicted
// sample, inserts the new one and sums the selected ranks. Uses swts_pkg.
module swts_scan #(
  parameter int WINDOW_LEN = swts_pkg::WINDOW_LEN_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  swts_pkg::scan_ctl_t                               ctl,
  input  logic [swts_pkg::SAMPLE_W-1:0]                     new_val,
  input  logic [swts_pkg::SAMPLE_W-1:0]                     old_val,
  input  logic [swts_pkg::SAMPLE_W-1:0]                     rd_data,
  input  logic [$clog2(WINDOW_LEN)-1:0]                     rank,
  input  logic [swts_pkg::CFG_W-1:0]                        skip_largest,
  input  logic [swts_pkg::CFG_W-1:0]                        keep_count,
  output logic [swts_pkg::SAMPLE_W-1:0]                     wr_data,
  output logic [swts_pkg::SAMPLE_W+$clog2(WINDOW_LEN)-1:0]  sum,
  output swts_pkg::scan_stat_t                              stat
);
  import swts_pkg::*;

  localparam int IDX_W = $clog2(WINDOW_LEN);
  localparam int SUM_W = SAMPLE_W + IDX_W;
  localparam int RW    = ((IDX_W > CFG_W) ? IDX_W : CFG_W) + 1;

  logic [SAMPLE_W-1:0] prev_r;   // old rank k-1
  logic [SAMPLE_W-1:0] cur_r;    // old rank k
  logic                removed_r;
  logic                inserted_r;
  logic [SUM_W-1:0]    sum_r;

  logic                rem_now;
  logic [SAMPLE_W-1:0] fwd;
  logic                put_new;
  logic                is_last;
  logic                in_range;
  logic [RW-1:0]       rank_x;
  logic [RW-1:0]       first_x;
  logic [RW-1:0]       last_x;

  // rd_data carries old rank k+1 while rank k is being decided.
  always_comb begin
    is_last = (rank == IDX_W'(WINDOW_LEN - 1));
    rem_now = removed_r | (cur_r == old_val);
    fwd     = rem_now ? rd_data : cur_r;
    put_new = !inserted_r && (is_last || (fwd <= new_val));
    if (inserted_r) begin
      wr_data = removed_r ? cur_r : prev_r;
    end else if (put_new) begin
      wr_data = new_val;
    end else begin
      wr_data = fwd;
    end
    rank_x   = RW'(rank);
    first_x  = RW'(skip_largest);
    last_x   = RW'(skip_largest) + RW'(keep_count);
    in_range = (rank_x >= first_x) && (rank_x < last_x);
  end

  always_ff @(posedge clk) begin
    if (ctl.run) begin
      cur_r  <= rd_data;
      prev_r <= cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      removed_r  <= 1'b0;
      inserted_r <= 1'b0;
    end else if (ctl.clear) begin
      removed_r  <= 1'b0;
      inserted_r <= 1'b0;
    end else if (ctl.step) begin
      removed_r  <= rem_now;
      inserted_r <= inserted_r | put_new;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      sum_r <= '0;
    end else if (ctl.step && in_range) begin
      sum_r <= sum_r + SUM_W'(wr_data);
    end
  end

  assign sum           = sum_r;
  assign stat.inserted = inserted_r;
  assign stat.removed  = removed_r;

endmodule

### rtl/sorted_window_trimmed_sum.sv
`timescale 1ns / 1ps
// Top level of the sorted window trimmed sum block: sequencer, configuration
// registers and result register. Uses swts_pkg, swts_ram and swts_scan.
//
// Usage: one count sample enters per transaction on the in_ channel
// (in_valid/in_ready, field in_sample). For each sample exactly one result
// transaction leaves on the out_ channel: out_trimmed_sum, the low 16 bits of
// the sum of ranks skip_largest .. skip_largest+keep_count-1 of the window
// ranked in descending order, and out_sum_overflow, set when that sum wrapped.
// Ranks past the end of the window contribute nothing.
// The window lives in a circular sample memory; a second memory keeps the same
// values in descending order. Each sample is accepted in the idle state, the
// sample it evicts is read in the fetch state, the ranked memory is streamed
// through the merge datapath at one entry per cycle in the scan state, and the
// result is loaded in the done state. That single read-modify-write pass over
// the ranked memory sets the rate. The result register lets a new sample be
// accepted while the previous result still waits; if the receiver stalls,
// the block holds the finished result and waits before loading the next one.
// Reset (rst_n low, synchronous) empties the window to all zeros, rewinds the
// write position and restores skip_largest to 1 and keep_count to 20. No
// clearing pass is needed: a window wrap flag and a ranked-memory flag make
// unwritten entries read as zero. Configuration is by APB writes at 0x0
// (skip_largest) and 0x4 (keep_count); pready is tied high.
module sorted_window_trimmed_sum #(
  parameter int WINDOW_LEN = swts_pkg::WINDOW_LEN_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [swts_pkg::SAMPLE_W-1:0]     in_sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [swts_pkg::SAMPLE_W-1:0]     out_trimmed_sum,
  output logic                              out_sum_overflow,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [swts_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [swts_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [swts_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import swts_pkg::*;

  localparam int IDX_W = $clog2(WINDOW_LEN);
  localparam int CNT_W = $clog2(WINDOW_LEN + 2);
  localparam int SUM_W = SAMPLE_W + IDX_W;

  // Sequencer and window bookkeeping.
  state_t              state_r;
  state_t              state_nxt;
  logic [CNT_W-1:0]    cnt_r;
  logic [CNT_W-1:0]    cnt_less2;
  logic [IDX_W-1:0]    rank;
  logic [IDX_W-1:0]    wp_r;       // slot the next sample overwrites
  logic                wrapped_r;  // every slot of the window has been written
  logic                ranked_vld_r; // ranked memory has been written once
  logic                old_vld_r;  // evicted slot held a written sample
  logic [SAMPLE_W-1:0] new_r;

  // Configuration.
  logic [CFG_W-1:0]    skip_largest_r;
  logic [CFG_W-1:0]    keep_count_r;
  logic                cfg_wr;
  reg_idx_t            reg_idx;

  // Result register.
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_trimmed_sum_r;
  logic                out_sum_overflow_r;

  // Memory and datapath connections.
  logic                win_access;
  logic [SAMPLE_W-1:0] win_q;
  logic                rk_re;
  logic [SAMPLE_W-1:0] rk_q;
  logic [SAMPLE_W-1:0] rk_q_gated;
  logic [SAMPLE_W-1:0] old_val;
  logic [SAMPLE_W-1:0] merge_data;
  logic [SUM_W-1:0]    sum;
  scan_ctl_t           ctl;
  scan_stat_t          stat;
  logic                load_out;
  logic                scan_end;

  // ---------------------------------------------------------------------------
  // APB configuration port. Writes land in the access phase; reads are free.
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_largest_r <= SKIP_RESET;
      keep_count_r   <= KEEP_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_SKIP_LARGEST: skip_largest_r <= pwdata[CFG_W-1:0];
        REG_KEEP_COUNT:   keep_count_r   <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SKIP_LARGEST: prdata = APB_DATA_W'(skip_largest_r);
      REG_KEEP_COUNT:   prdata = APB_DATA_W'(keep_count_r);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer. The scan counter issues ranked-memory reads at cnt and merges
  // rank cnt-2, so the write to a rank always trails its read, which passes
  // through the read data register and cur_r first.
  assign cnt_less2 = cnt_r - CNT_W'(2);
  assign rank      = cnt_less2[IDX_W-1:0];
  assign scan_end  = (cnt_r == CNT_W'(WINDOW_LEN + 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_FETCH;
      ST_FETCH: state_nxt = ST_SCAN;
      ST_SCAN:  if (scan_end) state_nxt = ST_DONE;
      ST_DONE:  if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    win_access = 1'b0;
    rk_re      = 1'b0;
    ctl        = '0;
    load_out   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_FETCH: begin
        win_access = 1'b1;
        ctl.clear  = 1'b1;
      end
      ST_SCAN: begin
        rk_re    = (cnt_r < CNT_W'(WINDOW_LEN));
        ctl.run  = 1'b1;
        ctl.step = (cnt_r >= CNT_W'(2));
      end
      ST_DONE: begin
        load_out = !out_valid_r || out_ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      wp_r         <= '0;
      wrapped_r    <= 1'b0;
      ranked_vld_r <= 1'b0;
      old_vld_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_FETCH) begin
        cnt_r     <= '0;
        old_vld_r <= wrapped_r;
        if (wp_r == IDX_W'(WINDOW_LEN - 1)) begin
          wp_r      <= '0;
          wrapped_r <= 1'b1;
        end else begin
          wp_r <= wp_r + IDX_W'(1);
        end
      end else if (state_r == ST_SCAN) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (load_out) begin
        ranked_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      new_r <= in_sample;
    end
  end

  // ---------------------------------------------------------------------------
  // Circular sample memory: the evicted sample is read and the new one written
  // at the same slot in one cycle. Slots not yet written read as zero.
  // ---------------------------------------------------------------------------
  swts_ram #(
    .DEPTH  (WINDOW_LEN),
    .DATA_W (SAMPLE_W),
    .ADDR_W (IDX_W)
  ) u_window_ram (
    .clk   (clk),
    .we    (win_access),
    .waddr (wp_r),
    .wdata (new_r),
    .re    (win_access),
    .raddr (wp_r),
    .rdata (win_q)
  );

  assign old_val = old_vld_r ? win_q : '0;

  // ---------------------------------------------------------------------------
  // Ranked memory, descending order. Before the first full pass every entry
  // reads as zero, which matches the cleared window.
  // ---------------------------------------------------------------------------
  swts_ram #(
    .DEPTH  (WINDOW_LEN),
    .DATA_W (SAMPLE_W),
    .ADDR_W (IDX_W)
  ) u_rank_ram (
    .clk   (clk),
    .we    (ctl.step),
    .waddr (rank),
    .wdata (merge_data),
    .re    (rk_re),
    .raddr (cnt_r[IDX_W-1:0]),
    .rdata (rk_q)
  );

  assign rk_q_gated = ranked_vld_r ? rk_q : '0;

  swts_scan #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .new_val      (new_r),
    .old_val      (old_val),
    .rd_data      (rk_q_gated),
    .rank         (rank),
    .skip_largest (skip_largest_r),
    .keep_count   (keep_count_r),
    .wr_data      (merge_data),
    .sum          (sum),
    .stat         (stat)
  );

  // ---------------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_trimmed_sum_r  <= sum[SAMPLE_W-1:0];
      out_sum_overflow_r <= |sum[SUM_W-1:SAMPLE_W];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_trimmed_sum  = out_trimmed_sum_r;
  assign out_sum_overflow = out_sum_overflow_r;

`ifndef SYNTHESIS
  // An accepted sample always moves the sequencer on to fetch the evicted one.
  a_accept_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_FETCH))
    else $error("accepted sample did not start a fetch");

  // By the end of a pass the evicted value was found and the new one placed.
  a_merge_complete: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> (stat.inserted && stat.removed))
    else $error("merge pass ended without removing or inserting a value");

  // A result only appears after a finished pass.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result loaded outside the done state");

  // The ranked memory is never written at the address being read.
  a_rank_ports: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.step && rk_re) |-> (rank != cnt_r[IDX_W-1:0]))
    else $error("ranked memory read and write collide");
`endif

endmodule
